>>> sv/pps_pkg.sv
// Package for the polygon plane splitter: verdict and side codes, sequencer states.
// No dependencies.
package pps_pkg;

  typedef enum logic [1:0] {
    VERDICT_BEHIND   = 2'd0,
    VERDICT_FRONT    = 2'd1,
    VERDICT_SPLIT    = 2'd2,
    VERDICT_OVERFLOW = 2'd3
  } verdict_e;

  localparam logic [1:0] SIDE_BACK  = 2'b01;
  localparam logic [1:0] SIDE_FRONT = 2'b10;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL,      // one product a cycle, accumulated
    ST_STORE,    // saturate, classify, write store
    ST_VERDICT,
    ST_SCAN,     // cyclic scan for first front and first back
    ST_CUTA,     // set up cut A, starting its division when needed
    ST_DIVA,
    ST_LERPA,    // interpolate five coordinates for cut A
    ST_CUTB,
    ST_DIVB,
    ST_LERPB,
    ST_EMIT
  } state_e;

endpackage

>>> sv/pps_div.sv
// Restoring divider for the cut parameter t = (num << 16) / den, one bit a cycle.
// Depends on nothing; used by polygon_plane_splitter.
module pps_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] num_i,   // 0 < num < den
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [15:0] quot_o
);

  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q;
  logic [15:0] quot_q, quot_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [33:0] trial;

  // One quotient bit a step.
  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[32:0], 1'b0} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      cnt_d  = 5'd16;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d  = trial;
        quot_d = {quot_q[14:0], 1'b1};
      end else begin
        rem_d  = {rem_q[32:0], 1'b0};
        quot_d = {quot_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = busy_q && (cnt_q == 5'd1);
  assign quot_o = quot_d;

endmodule

>>> sv/polygon_plane_splitter.sv
// Top level of the polygon plane splitter: sequencer, vertex store, one shared multiplier.
// Depends on pps_pkg and pps_div.
//
// A plane item is taken in the idle state. A vertex item passes through the
// accept cycle, three products through the one 33x33 multiplier, then the
// store write. On the final vertex the verdict state follows. A split polygon
// adds a cyclic side scan over the n stored vertices and two cut steps. A cut
// step only sets up when that cut is absent; otherwise, after setup, it runs
// the bit-serial divider unless t needs no division, then the multiplier
// interpolation. Emission then runs seven phases: each run emits one vertex
// per cycle, and each of the other five phases emits at most one vertex.
// Results leave one a cycle on out_valid_o and cannot be held off.
module polygon_plane_splitter #(
  parameter int MAX_VERTICES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        kind_i,
  input  logic [31:0] plane_a_i,
  input  logic [31:0] plane_b_i,
  input  logic [31:0] plane_c_i,
  input  logic [31:0] plane_d_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] tex_u_i,
  input  logic [31:0] tex_v_i,
  input  logic        final_vertex_i,
  output logic        out_valid_o,
  output logic [1:0]  verdict_o,
  output logic        piece_o,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic [31:0] out_u_o,
  output logic [31:0] out_v_o,
  output logic        piece_end_o,
  output logic        run_end_o
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  pps_pkg::state_e state_q, state_d;

  // Plane and margin.
  logic signed [31:0] pa_q, pb_q, pc_q, pd_q;
  logic [15:0] margin_q;

  // Vertex store (flip-flop rows, small).
  logic [31:0] sx_q [MAX_VERTICES];
  logic [31:0] sy_q [MAX_VERTICES];
  logic [31:0] sz_q [MAX_VERTICES];
  logic [31:0] su_q [MAX_VERTICES];
  logic [31:0] sv_q [MAX_VERTICES];
  logic signed [31:0] sd_q [MAX_VERTICES];
  logic [1:0]  ss_q [MAX_VERTICES];

  logic [CW-1:0] nv_q, nf_q, nb_q, no_q;
  logic          ovf_q, fin_q;

  // Incoming vertex latch.
  logic [31:0] vx_q, vy_q, vz_q, vu_q, vv_q;
  logic signed [65:0] acc_q;
  logic [1:0]  step_q;

  // Split bookkeeping.
  logic [IW-1:0] scan_q, ff_q, fb_q, idx_q;
  logic [CW-1:0] cnt_q;
  logic          cuta_q, cutb_q;
  logic [15:0]   t_q;
  logic [2:0]    co_q;
  logic [31:0]   ca_q [5];
  logic [31:0]   cb_q [5];
  logic [3:0]    ph_q;   // emit phase

  // Shared multiplier.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  assign prod = mul_a * mul_b;

  function automatic logic [IW-1:0] wrap(input logic [CW:0] v, input logic [CW-1:0] n);
    logic [CW:0] r;
    r = (v >= {1'b0, n}) ? v - {1'b0, n} : v;
    return r[IW-1:0];
  endfunction

  // Last front and last back index, from the scan result.
  logic [IW-1:0] lf, lb;
  assign lf = wrap({1'b0, CW'(ff_q)} + {1'b0, nf_q} - 1'b1, nv_q);
  assign lb = wrap({1'b0, CW'(fb_q)} + {1'b0, nb_q} - 1'b1, nv_q);

  // Cut helpers.
  logic [IW-1:0] c1, c2;
  logic signed [32:0] dd1, dd2, den, num;
  logic div_start, div_done;
  logic [15:0] div_q;
  logic        cut_b;
  assign cut_b = (state_q == pps_pkg::ST_CUTB) || (state_q == pps_pkg::ST_DIVB)
              || (state_q == pps_pkg::ST_LERPB);
  assign c1 = cut_b ? fb_q : ff_q;
  assign c2 = cut_b ? lf : lb;
  always_comb begin
    dd1 = 33'(sd_q[c1]);
    dd2 = 33'(sd_q[c2]);
    den = dd2 - dd1;
    num = -dd1;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
  end

  logic [31:0] e1, e2;
  always_comb begin
    unique case (co_q)
      3'd0: begin e1 = sx_q[c1]; e2 = sx_q[c2]; end
      3'd1: begin e1 = sy_q[c1]; e2 = sy_q[c2]; end
      3'd2: begin e1 = sz_q[c1]; e2 = sz_q[c2]; end
      3'd3: begin e1 = su_q[c1]; e2 = su_q[c2]; end
      default: begin e1 = sv_q[c1]; e2 = sv_q[c2]; end
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == pps_pkg::ST_MUL) begin
      unique case (step_q)
        2'd0: begin mul_a = 33'(pa_q); mul_b = 33'($signed(vx_q)); end
        2'd1: begin mul_a = 33'(pb_q); mul_b = 33'($signed(vy_q)); end
        default: begin mul_a = 33'(pc_q); mul_b = 33'($signed(vz_q)); end
      endcase
    end else begin
      mul_a = $signed(e2) - $signed(e1);
      mul_b = $signed({17'd0, t_q});
    end
  end

  // Saturated distance and side.
  logic signed [65:0] dsum;
  logic signed [31:0] dsat;
  logic [1:0]         side;
  always_comb begin
    dsum = acc_q + 66'(pd_q);
    if (dsum > 66'sd2147483647)       dsat = 32'sh7fffffff;
    else if (dsum < -66'sd2147483648) dsat = 32'sh80000000;
    else                              dsat = dsum[31:0];
    if (33'(dsat) < -$signed({17'd0, margin_q}))      side = pps_pkg::SIDE_BACK;
    else if (33'(dsat) > $signed({17'd0, margin_q})) side = pps_pkg::SIDE_FRONT;
    else side = pps_pkg::SIDE_BACK | pps_pkg::SIDE_FRONT;
  end

  logic [IW-1:0] scan_nx;
  assign scan_nx = wrap({1'b0, CW'(scan_q)} + 1'b1, nv_q);

  pps_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(num), .den_i(den),
    .done_o(div_done), .quot_o(div_q)
  );

  // Emit sequence: phases 0 cutA(front), 1 front run, 2 cutB(front),
  // 3 cutB(back), 4 back run, 5 cutA(back).
  logic       verdict_now;
  logic [1:0] verd;
  always_comb begin
    if (ovf_q) verd = pps_pkg::VERDICT_OVERFLOW;
    else if (nf_q == 0 || nf_q == no_q) verd = pps_pkg::VERDICT_BEHIND;
    else if (nb_q == 0 || nb_q == no_q) verd = pps_pkg::VERDICT_FRONT;
    else verd = pps_pkg::VERDICT_SPLIT;
    verdict_now = (verd != pps_pkg::VERDICT_SPLIT);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pps_pkg::ST_IDLE:
        if (start && kind_i) state_d = pps_pkg::ST_MUL;
      pps_pkg::ST_MUL:
        if (step_q == 2'd2) state_d = pps_pkg::ST_STORE;
      pps_pkg::ST_STORE:
        state_d = fin_q ? pps_pkg::ST_VERDICT : pps_pkg::ST_IDLE;
      pps_pkg::ST_VERDICT:
        state_d = verdict_now ? pps_pkg::ST_IDLE : pps_pkg::ST_SCAN;
      pps_pkg::ST_SCAN:
        if (32'(scan_q) == 32'(nv_q) - 1) state_d = pps_pkg::ST_CUTA;
      pps_pkg::ST_CUTA:
        if (ff_q == lb) state_d = pps_pkg::ST_CUTB;
        else if (den == 0 || num <= 0 || num >= den) state_d = pps_pkg::ST_LERPA;
        else state_d = pps_pkg::ST_DIVA;
      pps_pkg::ST_DIVA:
        if (div_done) state_d = pps_pkg::ST_LERPA;
      pps_pkg::ST_LERPA:
        if (co_q == 3'd4) state_d = pps_pkg::ST_CUTB;
      pps_pkg::ST_CUTB:
        if (fb_q == lf) state_d = pps_pkg::ST_EMIT;
        else if (den == 0 || num <= 0 || num >= den) state_d = pps_pkg::ST_LERPB;
        else state_d = pps_pkg::ST_DIVB;
      pps_pkg::ST_DIVB:
        if (div_done) state_d = pps_pkg::ST_LERPB;
      pps_pkg::ST_LERPB:
        if (co_q == 3'd4) state_d = pps_pkg::ST_EMIT;
      pps_pkg::ST_EMIT:
        if (ph_q == 4'd6) state_d = pps_pkg::ST_IDLE;
      default: state_d = pps_pkg::ST_IDLE;
    endcase
  end

  assign div_start = ((state_q == pps_pkg::ST_CUTA && ff_q != lb) ||
                      (state_q == pps_pkg::ST_CUTB && fb_q != lf)) &&
                     !(den == 0 || num <= 0 || num >= den);

  // Outputs.
  logic [31:0] o_c [5];
  logic        o_val, o_piece, o_pend, o_rend;
  logic [1:0]  o_verd;
  always_comb begin
    o_val = 1'b0; o_piece = 1'b0; o_pend = 1'b0; o_rend = 1'b0;
    o_verd = verd;
    for (int j = 0; j < 5; j++) o_c[j] = '0;
    busy = (state_q != pps_pkg::ST_IDLE);
    if (state_q == pps_pkg::ST_VERDICT && verdict_now) begin
      o_val = 1'b1; o_pend = 1'b1; o_rend = 1'b1;
    end else if (state_q == pps_pkg::ST_EMIT) begin
      o_verd = pps_pkg::VERDICT_SPLIT;
      unique case (ph_q)
        4'd0: begin
          o_val = cuta_q; o_c = ca_q;
        end
        4'd1, 4'd4: begin
          o_val = 1'b1; o_piece = (ph_q == 4'd4);
          o_c[0] = sx_q[idx_q]; o_c[1] = sy_q[idx_q]; o_c[2] = sz_q[idx_q];
          o_c[3] = su_q[idx_q]; o_c[4] = sv_q[idx_q];
          o_pend = (cnt_q == 1) && ((ph_q == 4'd1) ? !cutb_q : !cuta_q);
          o_rend = o_pend && (ph_q == 4'd4);
        end
        4'd2: begin o_val = cutb_q; o_c = cb_q; o_pend = 1'b1; end
        4'd3: begin o_val = cutb_q; o_c = cb_q; o_piece = 1'b1; end
        4'd5: begin
          o_val = cuta_q; o_c = ca_q; o_piece = 1'b1; o_pend = 1'b1; o_rend = 1'b1;
        end
        default: o_val = 1'b0;
      endcase
    end
  end

  assign cfg_ready_o = (state_q == pps_pkg::ST_IDLE);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pps_pkg::ST_IDLE;
      pa_q <= '0; pb_q <= '0; pc_q <= '0; pd_q <= '0;
      margin_q <= 16'd66;
      nv_q <= '0; nf_q <= '0; nb_q <= '0; no_q <= '0; ovf_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_o <= o_val;
      if (cfg_valid_i && cfg_ready_o) margin_q <= cfg_data_i;
      if (state_q == pps_pkg::ST_IDLE && start && !kind_i) begin
        pa_q <= plane_a_i; pb_q <= plane_b_i; pc_q <= plane_c_i; pd_q <= plane_d_i;
      end
      if (state_q == pps_pkg::ST_STORE) begin
        if (32'(nv_q) < MAX_VERTICES) begin
          nv_q <= nv_q + 1'b1;
          if (side[0]) nb_q <= nb_q + 1'b1;
          if (side[1]) nf_q <= nf_q + 1'b1;
          if (side == 2'b11) no_q <= no_q + 1'b1;
        end else ovf_q <= 1'b1;
      end
      if (state_d == pps_pkg::ST_IDLE && (state_q == pps_pkg::ST_VERDICT ||
          state_q == pps_pkg::ST_EMIT)) begin
        nv_q <= '0; nf_q <= '0; nb_q <= '0; no_q <= '0; ovf_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    verdict_o <= o_verd; piece_o <= o_piece;
    piece_end_o <= o_pend; run_end_o <= o_rend;
    out_x_o <= o_c[0]; out_y_o <= o_c[1]; out_z_o <= o_c[2];
    out_u_o <= o_c[3]; out_v_o <= o_c[4];

    unique case (state_q)
      pps_pkg::ST_IDLE: begin
        vx_q <= pos_x_i; vy_q <= pos_y_i; vz_q <= pos_z_i;
        vu_q <= tex_u_i; vv_q <= tex_v_i; fin_q <= final_vertex_i;
        acc_q <= '0; step_q <= '0;
      end
      pps_pkg::ST_MUL: begin
        acc_q  <= acc_q + (prod >>> 16);
        step_q <= step_q + 1'b1;
      end
      pps_pkg::ST_STORE: begin
        if (32'(nv_q) < MAX_VERTICES) begin
          sx_q[nv_q[IW-1:0]] <= vx_q; sy_q[nv_q[IW-1:0]] <= vy_q;
          sz_q[nv_q[IW-1:0]] <= vz_q; su_q[nv_q[IW-1:0]] <= vu_q;
          sv_q[nv_q[IW-1:0]] <= vv_q; sd_q[nv_q[IW-1:0]] <= dsat;
          ss_q[nv_q[IW-1:0]] <= side;
        end
        scan_q <= '0; ff_q <= '0; fb_q <= '0;
      end
      pps_pkg::ST_SCAN: begin
        if (ss_q[scan_nx][1] && !ss_q[scan_q][1]) ff_q <= scan_nx;
        if (ss_q[scan_nx][0] && !ss_q[scan_q][0]) fb_q <= scan_nx;
        scan_q <= scan_nx;
      end
      pps_pkg::ST_CUTA, pps_pkg::ST_CUTB: begin
        co_q <= '0;
        if (den == 0 || num <= 0) t_q <= '0;
        else t_q <= 16'hffff;
      end
      pps_pkg::ST_DIVA, pps_pkg::ST_DIVB:
        if (div_done) t_q <= div_q;
      pps_pkg::ST_LERPA, pps_pkg::ST_LERPB: begin
        if (state_q == pps_pkg::ST_LERPA) ca_q[co_q] <= e1 + prod[47:16];
        else cb_q[co_q] <= e1 + prod[47:16];
        co_q <= co_q + 1'b1;
        ph_q <= '0;
        idx_q <= ff_q;
        cnt_q <= nf_q;
      end
      pps_pkg::ST_EMIT: begin
        if (ph_q == 4'd1 || ph_q == 4'd4) begin
          idx_q <= wrap({1'b0, CW'(idx_q)} + 1'b1, nv_q);
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 1) ph_q <= ph_q + 1'b1;
        end else begin
          ph_q <= ph_q + 1'b1;
          if (ph_q == 4'd3) begin idx_q <= fb_q; cnt_q <= nb_q; end
        end
      end
      default: ;
    endcase
    if (state_q == pps_pkg::ST_SCAN && state_d == pps_pkg::ST_CUTA) begin
      cuta_q <= 1'b0; cutb_q <= 1'b0;
    end
    if (state_q == pps_pkg::ST_CUTA) cuta_q <= (ff_q != lb);
    if (state_q == pps_pkg::ST_CUTB) cutb_q <= (fb_q != lf);
    if (state_q == pps_pkg::ST_CUTB && fb_q == lf) begin
      ph_q <= '0; idx_q <= ff_q; cnt_q <= nf_q;
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for polygon_plane_splitter: directed and random polygons
// checked against an in-bench splitter predictor. Depends on pps_pkg and the RTL.
module tb_top;

  localparam int MAXV = 16;
  localparam int CYCLE_LIMIT = 2000000;

  // One input item as driven on the ports.
  typedef struct packed {
    logic        kind;
    logic [31:0] pa, pb, pc, pd, x, y, z, u, v;
    logic        fin;
  } item_t;

  // One emitted vertex or verdict.
  typedef struct packed {
    logic [1:0]  verdict;
    logic        piece;
    logic [31:0] x, y, z, u, v;
    logic        pend, rend;
  } vtx_t;

  logic clk_i = 0, rst_ni = 0, start = 0, cfg_valid_i = 0;
  logic busy, cfg_ready_o, out_valid_o;
  logic [15:0] cfg_data_i = '0;
  item_t cur = '0;
  logic [1:0] verdict_o;
  logic piece_o, piece_end_o, run_end_o;
  logic [31:0] out_x_o, out_y_o, out_z_o, out_u_o, out_v_o;

  polygon_plane_splitter u_top (
    .clk_i, .rst_ni, .start, .busy, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .kind_i(cur.kind), .plane_a_i(cur.pa), .plane_b_i(cur.pb), .plane_c_i(cur.pc),
    .plane_d_i(cur.pd), .pos_x_i(cur.x), .pos_y_i(cur.y), .pos_z_i(cur.z),
    .tex_u_i(cur.u), .tex_v_i(cur.v), .final_vertex_i(cur.fin),
    .out_valid_o, .verdict_o, .piece_o, .out_x_o, .out_y_o, .out_z_o,
    .out_u_o, .out_v_o, .piece_end_o, .run_end_o
  );

  initial forever #6 clk_i = ~clk_i;

  // Predictor state.
  longint coef [4];
  longint sx [MAXV], sy [MAXV], sz [MAXV], su [MAXV], sv [MAXV], sd [MAXV];
  logic [1:0] sside [MAXV];
  int nv, nf, nb, no;
  bit ovf;
  longint margin = 66;

  item_t pending_items[$];
  vtx_t  expected_vertices[$];
  int errors = 0, idle_pct = 0;
  bit hold = 0;
  bit taken = 0;
  longint cycles = 0;

  function automatic longint fshr(longint a);
    return a >>> 16;
  endfunction

  function automatic longint s32(logic [31:0] a);
    return longint'(signed'(a));
  endfunction

  function automatic vtx_t mk(logic [1:0] vd, logic pc, longint c[5]);
    vtx_t r;
    r = '0;
    r.verdict = vd; r.piece = pc;
    r.x = c[0][31:0]; r.y = c[1][31:0]; r.z = c[2][31:0];
    r.u = c[3][31:0]; r.v = c[4][31:0];
    return r;
  endfunction

  // Interpolated cut vertex between stored entries i1 and i2.
  task automatic cut_vertex(int i1, int i2, output longint c[5]);
    longint num, den, t;
    num = -sd[i1]; den = sd[i2] - sd[i1]; t = 0;
    if (den != 0) begin
      if (den < 0) begin num = -num; den = -den; end
      if (num <= 0) t = 0;
      else if (num >= den) t = 65535;
      else t = (num << 16) / den;
    end
    c[0] = sx[i1] + fshr((sx[i2] - sx[i1]) * t);
    c[1] = sy[i1] + fshr((sy[i2] - sy[i1]) * t);
    c[2] = sz[i1] + fshr((sz[i2] - sz[i1]) * t);
    c[3] = su[i1] + fshr((su[i2] - su[i1]) * t);
    c[4] = sv[i1] + fshr((sv[i2] - sv[i1]) * t);
  endtask

  // Update the predictor with one accepted item and queue its results.
  task automatic predict_split(item_t it);
    longint d, ca[5], cb[5], c[5], zc[5];
    int ff, fb, lf, lb, i, k, nx;
    bit cuta, cutb;
    vtx_t res[$];
    zc = '{0, 0, 0, 0, 0};
    if (!it.kind) begin
      coef[0] = s32(it.pa); coef[1] = s32(it.pb);
      coef[2] = s32(it.pc); coef[3] = s32(it.pd);
      return;
    end
    if (nv < MAXV) begin
      d = fshr(coef[0] * s32(it.x)) + fshr(coef[1] * s32(it.y))
        + fshr(coef[2] * s32(it.z)) + coef[3];
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < -64'sd2147483648) d = -64'sd2147483648;
      sx[nv] = s32(it.x); sy[nv] = s32(it.y); sz[nv] = s32(it.z);
      su[nv] = s32(it.u); sv[nv] = s32(it.v); sd[nv] = d;
      if (d < -margin) begin sside[nv] = pps_pkg::SIDE_BACK; nb++; end
      else if (d > margin) begin sside[nv] = pps_pkg::SIDE_FRONT; nf++; end
      else begin
        sside[nv] = pps_pkg::SIDE_BACK | pps_pkg::SIDE_FRONT; no++; nb++; nf++;
      end
      nv++;
    end else ovf = 1;
    if (!it.fin) return;
    if (ovf) res.push_back(mk(pps_pkg::VERDICT_OVERFLOW, 0, zc));
    else if (nf == 0 || nf == no) res.push_back(mk(pps_pkg::VERDICT_BEHIND, 0, zc));
    else if (nb == 0 || nb == no) res.push_back(mk(pps_pkg::VERDICT_FRONT, 0, zc));
    else begin
      ff = 0; fb = 0;
      for (i = 0; i < nv; i++) begin
        nx = (i + 1) % nv;
        if ((sside[nx] & pps_pkg::SIDE_FRONT) != 0 && (sside[i] & pps_pkg::SIDE_FRONT) == 0)
          ff = nx;
        if ((sside[nx] & pps_pkg::SIDE_BACK) != 0 && (sside[i] & pps_pkg::SIDE_BACK) == 0)
          fb = nx;
      end
      lf = (ff + nf - 1) % nv; lb = (fb + nb - 1) % nv;
      cuta = ff != lb; cutb = fb != lf;
      if (cuta) cut_vertex(ff, lb, ca);
      if (cutb) cut_vertex(fb, lf, cb);
      if (cuta) res.push_back(mk(pps_pkg::VERDICT_SPLIT, 0, ca));
      for (k = 0, i = ff; k < nf; k++, i = (i + 1) % nv) begin
        c[0] = sx[i]; c[1] = sy[i]; c[2] = sz[i]; c[3] = su[i]; c[4] = sv[i];
        res.push_back(mk(pps_pkg::VERDICT_SPLIT, 0, c));
      end
      if (cutb) res.push_back(mk(pps_pkg::VERDICT_SPLIT, 0, cb));
      res[res.size() - 1].pend = 1;
      if (cutb) res.push_back(mk(pps_pkg::VERDICT_SPLIT, 1, cb));
      for (k = 0, i = fb; k < nb; k++, i = (i + 1) % nv) begin
        c[0] = sx[i]; c[1] = sy[i]; c[2] = sz[i]; c[3] = su[i]; c[4] = sv[i];
        res.push_back(mk(pps_pkg::VERDICT_SPLIT, 1, c));
      end
      if (cuta) res.push_back(mk(pps_pkg::VERDICT_SPLIT, 1, ca));
    end
    res[res.size() - 1].pend = 1;
    res[res.size() - 1].rend = 1;
    foreach (res[j]) expected_vertices.push_back(res[j]);
    nv = 0; nf = 0; nb = 0; no = 0; ovf = 0;
  endtask

  // Driver: presents queued items, changing inputs on the falling edge.
  // An item that has not been taken yet stays on the ports.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !taken) begin
        // The item waits until the block is free.
      end else if (!hold && pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cur <= pending_items.pop_front();
        start <= 1;
      end else start <= 0;
    end
  end

  // Acceptance and result checking at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      taken <= start && !busy;
      if (start && !busy) predict_split(cur);
      if (out_valid_o) begin
        if (expected_vertices.size() == 0) begin
          $display("%0t: unexpected result verdict %0d x %h", $time, verdict_o, out_x_o);
          errors++;
        end else begin : chk
          vtx_t e, a;
          e = expected_vertices.pop_front();
          a = '{verdict_o, piece_o, out_x_o, out_y_o, out_z_o, out_u_o, out_v_o,
                piece_end_o, run_end_o};
          if (a !== e) begin
            $display("%0t: mismatch expected %h actual %h", $time, e, a);
            errors++;
          end
        end
      end
    end
  end

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'(signed'($urandom_range(20, 0)) - 10) << 16;
      2: return {{16{1'($urandom_range(1))}}, 16'($urandom())};
      default: return 32'(int'($urandom_range(8000)) - 4000) << 8;
    endcase
  endfunction

  function automatic item_t vtx_item(logic [31:0] x, y, z, logic fin);
    item_t it;
    it = '0;
    it.kind = 1; it.x = x; it.y = y; it.z = z;
    it.u = $urandom(); it.v = $urandom(); it.fin = fin;
    return it;
  endfunction

  function automatic item_t plane_item(logic [31:0] a, b, c, d);
    item_t it;
    it = '0;
    it.pa = a; it.pb = b; it.pc = c; it.pd = d;
    it.fin = 1'($urandom_range(1));
    it.x = $urandom();
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || start || busy || expected_vertices.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_margin(logic [15:0] m);
    wait_drained();
    @(negedge clk_i);
    cfg_data_i <= m; cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    margin = m;
    @(negedge clk_i) cfg_valid_i <= 0;
  endtask

  task automatic random_polygons(int count);
    int n, k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0)
        pending_items.push_back(plane_item(rnd_coord(), rnd_coord(), rnd_coord(), $urandom()));
      n = ($urandom_range(19) == 0) ? $urandom_range(20, 17) : $urandom_range(6, 1);
      for (int j = 0; j < n; j++)
        pending_items.push_back(vtx_item(rnd_coord(), rnd_coord(), rnd_coord(), j == n - 1));
    end
  endtask

  // Stimulus: directed polygons, then random phases under several idle rates.
  initial begin
    int ph;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1;
    // Plane x = 0; square straddling it gives a split with two cuts.
    pending_items.push_back(plane_item(32'h0001_0000, 0, 0, 0));
    pending_items.push_back(vtx_item(32'hFFFF_0000, 0, 0, 1'b0));
    pending_items.push_back(vtx_item(32'h0001_0000, 0, 0, 1'b0));
    pending_items.push_back(vtx_item(32'h0001_0000, 32'h0001_0000, 0, 1'b0));
    pending_items.push_back(vtx_item(32'hFFFF_0000, 32'h0001_0000, 0, 1'b1));
    // Wholly in front, wholly behind, and a vertex lying on the plane.
    pending_items.push_back(vtx_item(32'h0002_0000, 0, 0, 1'b0));
    pending_items.push_back(vtx_item(32'h0003_0000, 0, 0, 1'b1));
    pending_items.push_back(vtx_item(32'hFFFE_0000, 0, 0, 1'b0));
    pending_items.push_back(vtx_item(0, 0, 0, 1'b1));
    pending_items.push_back(vtx_item(0, 32'h7FFF_FFFF, 0, 1'b0));
    pending_items.push_back(vtx_item(32'h0001_0000, 0, 0, 1'b0));
    pending_items.push_back(vtx_item(32'hFFFF_0000, 0, 0, 1'b1));
    // Saturating distance with extreme coefficients and positions.
    pending_items.push_back(plane_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                       32'h8000_0000));
    pending_items.push_back(vtx_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    pending_items.push_back(vtx_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    pending_items.push_back(vtx_item(32'hFFFF_FFFF, 0, 32'h0000_0001, 1'b1));
    // Single-vertex polygon and a polygon longer than the store.
    pending_items.push_back(vtx_item(0, 0, 0, 1'b1));
    for (int j = 0; j < 18; j++)
      pending_items.push_back(vtx_item($urandom(), $urandom(), $urandom(), j == 17));
    set_margin(16'd0);
    pending_items.push_back(plane_item(32'h0001_0000, 32'h0000_8000, 0, 32'hFFFF_8000));
    random_polygons(4);
    set_margin(16'hFFFF);
    random_polygons(4);
    // Pause until every expected result has come, then go on.
    hold = 1;
    while (expected_vertices.size() > 0 || busy || start) @(posedge clk_i);
    hold = 0;
    for (ph = 0; ph < 4; ph++) begin
      set_margin(ph == 3 ? 16'd66 : 16'($urandom_range(2000)));
      idle_pct = (ph == 1) ? 49 : (ph == 2) ? 30 : 0;
      random_polygons(3);
    end
    wait_drained();
    if (errors == 0) $display("** polygon_plane_splitter: PASSED **");
    else $display("** polygon_plane_splitter: FAILED **");
    $finish;
  end

  // Watchdog.
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("** polygon_plane_splitter: FAILED **");
    $finish;
  end
endmodule
